/* sv/uvs_pkg.sv */
package uvs_pkg;

  localparam int PH_W = 32;
  localparam int XY_W = 32;
  localparam int N_W = 34;
  localparam int CORDIC_STEPS = 24;
  localparam int DIV_STEPS = 32;

  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 32'sd652032874;

  localparam logic signed [XY_W-1:0] ATAN_TURNS [0:CORDIC_STEPS-1] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331, 32'sd21354465, 32'sd10679838, 32'sd5340245,
    32'sd2670163, 32'sd1335087, 32'sd667544, 32'sd333772,
    32'sd166885, 32'sd83443, 32'sd41721, 32'sd20861,
    32'sd10430, 32'sd5215, 32'sd2608, 32'sd1304,
    32'sd652, 32'sd326, 32'sd163, 32'sd81
  };

  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_RINGS = 2'd1;
  localparam logic [1:0] REG_SECTORS = 2'd2;

  typedef logic signed [XY_W-1:0] xy_t;
  typedef logic signed [N_W-1:0] norm_t;

  typedef struct packed {
    logic oor;
    logic has_quad;
    logic [15:0] idx_here;
    logic [15:0] idx_next_ring;
    logic [15:0] idx_next_both;
    logic [15:0] idx_next_sector;
  } side_t;

endpackage

/* sv/uvs_phase_div.sv */
module uvs_phase_div (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic [7:0] num_hi [2],
  input  logic [31:0] num_lo [2],
  input  logic [7:0] den [2],
  input  uvs_pkg::side_t in_side,
  output logic out_valid,
  output logic [31:0] quot [2],
  output uvs_pkg::side_t out_side
);

  localparam int STEPS = uvs_pkg::DIV_STEPS;

  logic [7:0] rem [0:STEPS][2];
  logic [31:0] lo [0:STEPS][2];
  logic [31:0] q [0:STEPS][2];
  logic vld [0:STEPS];
  uvs_pkg::side_t side [0:STEPS];

  assign vld[0] = in_valid;
  assign side[0] = in_side;
  for (genvar l = 0; l < 2; l++) begin : g_in
    assign rem[0][l] = num_hi[l];
    assign lo[0][l] = num_lo[l];
    assign q[0][l] = '0;
  end

  for (genvar g = 0; g < STEPS; g++) begin : g_stage
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [8:0] trial;
      logic ge;
      assign trial = {rem[g][l], lo[g][l][31]};
      assign ge = trial >= {1'b0, den[l]};
      always_ff @(posedge clk) begin
        rem[g+1][l] <= ge ? 8'(trial - {1'b0, den[l]}) : trial[7:0];
        lo[g+1][l] <= {lo[g][l][30:0], 1'b0};
        q[g+1][l] <= {q[g][l][30:0], ge};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else begin
        vld[g+1] <= vld[g];
      end
      side[g+1] <= side[g];
    end
  end

  assign out_valid = vld[STEPS];
  assign out_side = side[STEPS];
  assign quot[0] = q[STEPS][0];
  assign quot[1] = q[STEPS][1];

endmodule

/* sv/uvs_cordic.sv */
module uvs_cordic (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic [31:0] phase [2],
  input  uvs_pkg::side_t in_side,
  output logic out_valid,
  output uvs_pkg::xy_t cos_q [2],
  output uvs_pkg::xy_t sin_q [2],
  output uvs_pkg::side_t out_side
);

  localparam int STEPS = uvs_pkg::CORDIC_STEPS;

  uvs_pkg::xy_t xs [0:STEPS][2];
  uvs_pkg::xy_t ys [0:STEPS][2];
  uvs_pkg::xy_t zs [0:STEPS][2];
  logic [1:0] quad [0:STEPS][2];
  logic vld [0:STEPS];
  uvs_pkg::side_t side [0:STEPS];

  assign vld[0] = in_valid;
  assign side[0] = in_side;
  for (genvar l = 0; l < 2; l++) begin : g_in
    assign xs[0][l] = uvs_pkg::CORDIC_GAIN;
    assign ys[0][l] = '0;
    assign zs[0][l] = {2'b00, phase[l][29:0]};
    assign quad[0][l] = phase[l][31:30];
  end

  for (genvar g = 0; g < STEPS; g++) begin : g_stage
    for (genvar l = 0; l < 2; l++) begin : g_lane
      uvs_pkg::xy_t dx;
      uvs_pkg::xy_t dy;
      assign dx = ys[g][l] >>> g;
      assign dy = xs[g][l] >>> g;
      always_ff @(posedge clk) begin
        if (!zs[g][l][31]) begin
          xs[g+1][l] <= xs[g][l] - dx;
          ys[g+1][l] <= ys[g][l] + dy;
          zs[g+1][l] <= zs[g][l] - uvs_pkg::ATAN_TURNS[g];
        end else begin
          xs[g+1][l] <= xs[g][l] + dx;
          ys[g+1][l] <= ys[g][l] - dy;
          zs[g+1][l] <= zs[g][l] + uvs_pkg::ATAN_TURNS[g];
        end
        quad[g+1][l] <= quad[g][l];
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else begin
        vld[g+1] <= vld[g];
      end
      side[g+1] <= side[g];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld[STEPS];
    end
    out_side <= side[STEPS];
    for (int l = 0; l < 2; l++) begin
      unique case (quad[STEPS][l])
        2'd0: begin
          cos_q[l] <= xs[STEPS][l];
          sin_q[l] <= ys[STEPS][l];
        end
        2'd1: begin
          cos_q[l] <= -ys[STEPS][l];
          sin_q[l] <= xs[STEPS][l];
        end
        2'd2: begin
          cos_q[l] <= -xs[STEPS][l];
          sin_q[l] <= -ys[STEPS][l];
        end
        default: begin
          cos_q[l] <= ys[STEPS][l];
          sin_q[l] <= -xs[STEPS][l];
        end
      endcase
    end
  end

endmodule

/* sv/uv_sphere_vertex_generator_top.sv */
// Takes one grid point (ring_index, sector_index) per cycle and gives its UV sphere vertex:
// position, unit normal, quad corner indices and flags. A new point may be started in
// every cycle; busy never rises. The result appears with done high once the point has
// passed a 32-stage bit-per-stage phase divider, a 24-stage CORDIC for the ring and sector
// angles and five stages for quadrant fold, products and rounding. The receiver cannot
// stall the output, so each result must be taken in its done cycle.
// Write radius, ring_count and sector_count only while no point is in flight.
module uv_sphere_vertex_generator_top #(
  parameter int MAX_DIVISIONS = 256,
  parameter int UNIT_FRAC_BITS = 14
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [7:0] ring_index,
  input  logic [7:0] sector_index,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data,
  output logic done,
  output logic signed [16:0] pos_x,
  output logic signed [16:0] pos_y,
  output logic signed [16:0] pos_z,
  output logic signed [15:0] normal_x,
  output logic signed [15:0] normal_y,
  output logic signed [15:0] normal_z,
  output logic out_of_range,
  output logic has_quad,
  output logic [15:0] idx_here,
  output logic [15:0] idx_next_ring,
  output logic [15:0] idx_next_both,
  output logic [15:0] idx_next_sector
);

  localparam int SH = 30 - UNIT_FRAC_BITS;
  localparam uvs_pkg::norm_t NHALF =
    (SH == 0) ? '0 : (uvs_pkg::norm_t'(1) <<< ((SH == 0) ? 0 : SH - 1));
  localparam uvs_pkg::norm_t NLIM = uvs_pkg::norm_t'(1) <<< UNIT_FRAC_BITS;
  localparam logic [8:0] MAX_CNT = 9'(MAX_DIVISIONS);

  logic [15:0] radius;
  logic [8:0] ring_count;
  logic [8:0] sector_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= 16'd256;
      ring_count <= 9'd16;
      sector_count <= 9'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        uvs_pkg::REG_RADIUS: radius <= cfg_data;
        uvs_pkg::REG_RINGS: ring_count <= cfg_data[8:0];
        uvs_pkg::REG_SECTORS: sector_count <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic [8:0] nr;
  logic [8:0] ns;
  logic [7:0] den [2];
  logic [7:0] half [2];

  always_comb begin
    if (ring_count < 9'd2) begin
      nr = 9'd2;
    end else if (ring_count > MAX_CNT) begin
      nr = MAX_CNT;
    end else begin
      nr = ring_count;
    end
    if (sector_count < 9'd2) begin
      ns = 9'd2;
    end else if (sector_count > MAX_CNT) begin
      ns = MAX_CNT;
    end else begin
      ns = sector_count;
    end
    den[0] = 8'(nr - 9'd1);
    den[1] = 8'(ns - 9'd1);
    half[0] = den[0] >> 1;
    half[1] = den[1] >> 1;
  end

  // Entry stage: grid checks, corner indices and divider operands.
  logic e_valid;
  uvs_pkg::side_t e_side;
  logic [7:0] e_hi [2];
  logic [31:0] e_lo [2];

  logic oor_c;
  logic quad_c;
  logic [16:0] base_c;
  logic [16:0] next_c;

  always_comb begin
    oor_c = ({1'b0, ring_index} >= nr) || ({1'b0, sector_index} >= ns);
    quad_c = ({1'b0, ring_index} + 9'd1 < nr) && ({1'b0, sector_index} + 9'd1 < ns);
    base_c = 17'(ring_index) * 17'(ns) + 17'(sector_index);
    next_c = base_c + 17'(ns);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else begin
      e_valid <= start && !busy;
    end
    e_side.oor <= oor_c;
    e_side.has_quad <= quad_c;
    e_side.idx_here <= oor_c ? 16'd0 : base_c[15:0];
    e_side.idx_next_ring <= quad_c ? next_c[15:0] : 16'd0;
    e_side.idx_next_both <= quad_c ? 16'(next_c + 17'd1) : 16'd0;
    e_side.idx_next_sector <= quad_c ? 16'(base_c + 17'd1) : 16'd0;
    e_hi[0] <= {1'b0, ring_index[7:1]};
    e_lo[0] <= {ring_index[0], 31'd0} + 32'(half[0]);
    e_hi[1] <= (sector_index == den[1]) ? 8'd0 : sector_index;
    e_lo[1] <= 32'(half[1]);
  end

  logic d_valid;
  logic [31:0] d_phase [2];
  uvs_pkg::side_t d_side;

  uvs_phase_div u_div (
    .clk(clk),
    .rst(rst),
    .in_valid(e_valid),
    .num_hi(e_hi),
    .num_lo(e_lo),
    .den(den),
    .in_side(e_side),
    .out_valid(d_valid),
    .quot(d_phase),
    .out_side(d_side)
  );

  logic c_valid;
  uvs_pkg::xy_t c_cos [2];
  uvs_pkg::xy_t c_sin [2];
  uvs_pkg::side_t c_side;

  uvs_cordic u_cordic (
    .clk(clk),
    .rst(rst),
    .in_valid(d_valid),
    .phase(d_phase),
    .in_side(d_side),
    .out_valid(c_valid),
    .cos_q(c_cos),
    .sin_q(c_sin),
    .out_side(c_side)
  );

  // Normal products.
  logic m1_valid;
  uvs_pkg::side_t m1_side;
  logic signed [63:0] m1_prod_x;
  logic signed [63:0] m1_prod_z;
  uvs_pkg::norm_t m1_ny;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
    end else begin
      m1_valid <= c_valid;
    end
    m1_side <= c_side;
    m1_prod_x <= c_cos[1] * c_sin[0];
    m1_prod_z <= c_sin[1] * c_sin[0];
    m1_ny <= -uvs_pkg::norm_t'(c_cos[0]);
  end

  logic signed [63:0] rx_c;
  logic signed [63:0] rz_c;
  assign rx_c = m1_prod_x + 64'sd536870912;
  assign rz_c = m1_prod_z + 64'sd536870912;

  logic m2_valid;
  uvs_pkg::side_t m2_side;
  uvs_pkg::norm_t m2_n [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_valid <= 1'b0;
    end else begin
      m2_valid <= m1_valid;
    end
    m2_side <= m1_side;
    m2_n[0] <= uvs_pkg::norm_t'(rx_c[63:30]);
    m2_n[1] <= m1_ny;
    m2_n[2] <= uvs_pkg::norm_t'(rz_c[63:30]);
  end

  // Position products and normal rounding.
  logic m3_valid;
  uvs_pkg::side_t m3_side;
  logic signed [50:0] m3_pos [3];
  uvs_pkg::norm_t m3_nq [3];
  logic signed [16:0] radius_s;
  assign radius_s = {1'b0, radius};

  always_ff @(posedge clk) begin
    if (rst) begin
      m3_valid <= 1'b0;
    end else begin
      m3_valid <= m2_valid;
    end
    m3_side <= m2_side;
    for (int j = 0; j < 3; j++) begin
      m3_pos[j] <= m2_n[j] * radius_s;
      m3_nq[j] <= (m2_n[j] + NHALF) >>> SH;
    end
  end

  logic signed [16:0] pos_c [3];
  logic signed [15:0] nrm_c [3];

  always_comb begin
    logic signed [50:0] pr;
    logic signed [20:0] pv;
    for (int j = 0; j < 3; j++) begin
      pr = m3_pos[j] + 51'sd536870912;
      pv = pr[50:30];
      if (pv > 21'sd65535) begin
        pos_c[j] = 17'sd65535;
      end else if (pv < -21'sd65535) begin
        pos_c[j] = -17'sd65535;
      end else begin
        pos_c[j] = pv[16:0];
      end
      if (m3_nq[j] > NLIM) begin
        nrm_c[j] = NLIM[15:0];
      end else if (m3_nq[j] < -NLIM) begin
        nrm_c[j] = 16'(-NLIM);
      end else begin
        nrm_c[j] = m3_nq[j][15:0];
      end
      if (m3_side.oor) begin
        pos_c[j] = '0;
        nrm_c[j] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= m3_valid;
    end
    pos_x <= pos_c[0];
    pos_y <= pos_c[1];
    pos_z <= pos_c[2];
    normal_x <= nrm_c[0];
    normal_y <= nrm_c[1];
    normal_z <= nrm_c[2];
    out_of_range <= m3_side.oor;
    has_quad <= m3_side.has_quad;
    idx_here <= m3_side.idx_here;
    idx_next_ring <= m3_side.idx_next_ring;
    idx_next_both <= m3_side.idx_next_both;
    idx_next_sector <= m3_side.idx_next_sector;
  end

endmodule

/* sv/uvs_checker.sv */
module uvs_checker (
  input logic clk,
  input logic rst,
  input logic done,
  input logic signed [16:0] pos_x,
  input logic signed [16:0] pos_y,
  input logic signed [16:0] pos_z,
  input logic signed [15:0] normal_x,
  input logic signed [15:0] normal_y,
  input logic signed [15:0] normal_z,
  input logic out_of_range,
  input logic has_quad,
  input logic [15:0] idx_here,
  input logic [15:0] idx_next_ring,
  input logic [15:0] idx_next_both,
  input logic [15:0] idx_next_sector
);

  // No transfer can come out of a freshly reset pipeline.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    done && out_of_range |-> pos_x == 0 && pos_y == 0 && pos_z == 0 &&
      normal_x == 0 && normal_y == 0 && normal_z == 0 && !has_quad &&
      idx_here == 0 && idx_next_ring == 0 && idx_next_both == 0 && idx_next_sector == 0)
    else $error("out of range result carries data");

  a_quad_neighbors: assert property (@(posedge clk) disable iff (rst)
    done && has_quad |-> idx_next_sector == 16'(idx_here + 16'd1) &&
      idx_next_both == 16'(idx_next_ring + 16'd1))
    else $error("quad corners are not adjacent");

  a_no_quad_zero: assert property (@(posedge clk) disable iff (rst)
    done && !has_quad |-> idx_next_ring == 0 && idx_next_both == 0 && idx_next_sector == 0)
    else $error("corner indices given without a quad");

endmodule

bind uv_sphere_vertex_generator_top uvs_checker u_uvs_checker (.*);

/* tb/tb_uv_sphere_vertex_generator_top.sv */
module tb_uv_sphere_vertex_generator_top;

  localparam int PIPE_LATENCY = 62;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int N_RANDOM = 880;
  localparam int CALM_TAIL = 150;

  typedef struct packed {
    logic signed [16:0] pos_x;
    logic signed [16:0] pos_y;
    logic signed [16:0] pos_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic out_of_range;
    logic has_quad;
    logic [15:0] idx_here;
    logic [15:0] idx_next_ring;
    logic [15:0] idx_next_both;
    logic [15:0] idx_next_sector;
  } vertex_t;

  typedef struct {
    logic [7:0] ring;
    logic [7:0] sector;
    bit typed_oor;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [7:0] ring_index = 8'd0;
  logic [7:0] sector_index = 8'd0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = uvs_pkg::REG_RADIUS;
  logic [15:0] cfg_data = 16'd0;
  logic done;
  logic signed [16:0] pos_x, pos_y, pos_z;
  logic signed [15:0] normal_x, normal_y, normal_z;
  logic out_of_range, has_quad;
  logic [15:0] idx_here, idx_next_ring, idx_next_both, idx_next_sector;
  logic typed_oor = 1'b0;

  logic [15:0] model_radius;
  logic [8:0] model_rings;
  logic [8:0] model_sectors;
  vertex_t expected_vertices[$];
  int mismatches = 0;
  int items_sent = 0;
  int results_checked = 0;
  int oor_results = 0;
  int quad_results = 0;

  uv_sphere_vertex_generator_top uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .ring_index(ring_index), .sector_index(sector_index),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .out_of_range(out_of_range), .has_quad(has_quad), .idx_here(idx_here),
    .idx_next_ring(idx_next_ring), .idx_next_both(idx_next_both),
    .idx_next_sector(idx_next_sector)
  );

  always #10 clk = ~clk;

  function automatic longint eff_count(logic [8:0] v);
    if (v < 2) return 2;
    if (v > 256) return 256;
    return v;
  endfunction

  function automatic longint round_to(longint v, int n);
    if (n == 0) return v;
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clamp(longint v, longint lim);
    return v < -lim ? -lim : (v > lim ? lim : v);
  endfunction

  task automatic cordic_sincos(input logic [31:0] phase, output longint c,
                               output longint s);
    longint x, y, z, dx, dy;
    x = uvs_pkg::CORDIC_GAIN;
    y = 0;
    z = longint'(phase[29:0]);
    for (int i = 0; i < uvs_pkg::CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= uvs_pkg::ATAN_TURNS[i];
      end else begin
        x += dx; y -= dy; z += uvs_pkg::ATAN_TURNS[i];
      end
    end
    case (phase[31:30])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  task automatic predict_vertex(input logic [7:0] r, input logic [7:0] s,
                                output vertex_t v);
    longint nr, ns, cr, sr, cs, ss, p, q;
    longint unit[3];
    logic [63:0] ph;
    logic [31:0] phr, phs;
    v = '0;
    nr = eff_count(model_rings);
    ns = eff_count(model_sectors);
    if (r >= nr || s >= ns) begin
      v.out_of_range = 1'b1;
      return;
    end
    ph = ((64'(r) << 31) + 64'((nr - 1) / 2)) / 64'(nr - 1);
    phr = ph[31:0];
    ph = ((64'(s) << 32) + 64'((ns - 1) / 2)) / 64'(ns - 1);
    phs = ph[31:0];
    cordic_sincos(phr, cr, sr);
    cordic_sincos(phs, cs, ss);
    unit[0] = round_to(cs * sr, 30);
    unit[1] = -cr;
    unit[2] = round_to(ss * sr, 30);
    for (int j = 0; j < 3; j++) begin
      p = clamp(round_to(unit[j] * longint'(model_radius), 30), 65535);
      q = clamp(round_to(unit[j], 30 - 14), 16384);
      case (j)
        0: begin v.pos_x = p[16:0]; v.normal_x = q[15:0]; end
        1: begin v.pos_y = p[16:0]; v.normal_y = q[15:0]; end
        default: begin v.pos_z = p[16:0]; v.normal_z = q[15:0]; end
      endcase
    end
    v.idx_here = 16'(r * ns + s);
    if (r + 1 < nr && s + 1 < ns) begin
      v.has_quad = 1'b1;
      v.idx_next_ring = 16'((r + 1) * ns + s);
      v.idx_next_both = 16'((r + 1) * ns + s + 1);
      v.idx_next_sector = 16'(r * ns + s + 1);
    end
  endtask

  always @(posedge clk) begin
    vertex_t want, got;
    if (rst) begin
      model_radius <= 16'd256;
      model_rings <= 9'd16;
      model_sectors <= 9'd16;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          uvs_pkg::REG_RADIUS: model_radius <= cfg_data;
          uvs_pkg::REG_RINGS: model_rings <= cfg_data[8:0];
          uvs_pkg::REG_SECTORS: model_sectors <= cfg_data[8:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (typed_oor) begin
          want = '0;
          want.out_of_range = 1'b1;
        end else begin
          predict_vertex(ring_index, sector_index, want);
        end
        expected_vertices = {expected_vertices, want};
      end
      if (done) begin
        got = '{pos_x, pos_y, pos_z, normal_x, normal_y, normal_z, out_of_range,
                has_quad, idx_here, idx_next_ring, idx_next_both, idx_next_sector};
        if (expected_vertices.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result: %p", got);
        end else begin
          want = expected_vertices.pop_front();
          results_checked++;
          if (got.out_of_range) oor_results++;
          if (got.has_quad) quad_results++;
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch:\n  expected %p\n  actual   %p", want, got);
          end
        end
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_point(input logic [7:0] r, input logic [7:0] s, input bit lit);
    @(negedge clk);
    start <= 1'b1;
    ring_index <= r;
    sector_index <= s;
    typed_oor <= lit;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic maybe_idle(input bit allow);
    if (allow && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      start <= 1'b0;
      ring_index <= 8'($urandom);
      sector_index <= 8'($urandom);
      repeat ($urandom_range(0, 2)) @(negedge clk);
    end
  endtask

  task automatic drain;
    @(negedge clk);
    start <= 1'b0;
    while (expected_vertices.size() != 0) @(posedge clk);
  endtask

  dir_row_t directed[] = '{
    '{8'd0, 8'd0, 0}, '{8'd15, 8'd15, 0}, '{8'd14, 8'd14, 0},
    '{8'd0, 8'd15, 0}, '{8'd15, 8'd0, 0}, '{8'd7, 8'd4, 0},
    '{8'd3, 8'd12, 0}, '{8'd8, 8'd8, 0}, '{8'd1, 8'd1, 0},
    '{8'd4, 8'd11, 0}, '{8'd12, 8'd3, 0}, '{8'd14, 8'd0, 0},
    '{8'd16, 8'd0, 1}, '{8'd0, 8'd16, 1}, '{8'd255, 8'd255, 1},
    '{8'd255, 8'd0, 1}, '{8'd0, 8'd255, 1}, '{8'd170, 8'd85, 1}
  };

  initial begin
    logic [15:0] radius_set[8];
    logic [15:0] ring_set[8];
    logic [15:0] sector_set[8];
    int nr, ns, left;
    logic [7:0] r, s;
    radius_set = '{16'd65535, 16'd0, 16'd1, 16'd32768,
                   16'd256, 16'd0, 16'd0, 16'd0};
    ring_set = '{16'd256, 16'd2, 16'd0, 16'hFFFF,
                 16'd3, 16'd0, 16'd0, 16'd0};
    sector_set = '{16'd256, 16'd2, 16'd1, 16'd300,
                   16'd255, 16'd0, 16'd0, 16'd0};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (directed[i]) begin
      send_point(directed[i].ring, directed[i].sector, directed[i].typed_oor);
      maybe_idle(1);
    end
    drain();
    left = N_RANDOM;
    for (int ph = 0; ph < 8; ph++) begin
      if (ph >= 5) begin
        radius_set[ph] = 16'($urandom);
        ring_set[ph] = 16'($urandom_range(2, 256));
        sector_set[ph] = 16'($urandom_range(2, 256));
      end
      write_reg(uvs_pkg::REG_RADIUS, radius_set[ph]);
      write_reg(uvs_pkg::REG_RINGS, ring_set[ph]);
      write_reg(uvs_pkg::REG_SECTORS, sector_set[ph]);
      if (ph == 2) write_reg(REG_UNUSED, 16'hFFFF);
      nr = int'(eff_count(ring_set[ph][8:0]));
      ns = int'(eff_count(sector_set[ph][8:0]));
      for (int k = 0; k < N_RANDOM / 8; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          r = 8'($urandom);
          s = 8'($urandom);
        end else begin
          r = 8'($urandom_range(0, nr - 1));
          s = 8'($urandom_range(0, ns - 1));
        end
        send_point(r, s, 0);
        left--;
        maybe_idle(left > CALM_TAIL);
      end
      drain();
    end
    repeat (PIPE_LATENCY + 8) @(posedge clk);
    $display("Sent %0d grid points over 9 register settings, radius and counts at extremes;",
             items_sent);
    $display("checked %0d vertices, %0d out of grid, %0d with a quad.",
             results_checked, oor_results, quad_results);
    if (mismatches == 0 && expected_vertices.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_vertices.size());
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout");
    $display("status: fail");
    $finish;
  end

endmodule
